>>> rtl/core/sppg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppg_pkg
// Shared widths, fixed-point constants, lane types and the quarter-wave
// sine magnitude table of the plasma pixel generator.
// ----------------------------------------------------------------------------
package sppg_pkg;

    localparam int COORD_BITS      = 10;
    localparam int SINE_TABLE_BITS = 10;
    localparam int ANGLE_W         = 16;
    localparam int TERM_W          = 16;
    localparam int MAG_W           = 15;
    localparam int GREY_W          = 8;
    localparam int SUM4_W          = TERM_W + 2;

    localparam int RAD_W = 30;
    localparam logic [63:0] RAD_Q16 = 64'd683565276;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int AMP_Q8 = 32512;

    // x*x + y*y, scaled by 2^16 for the Q8 radius
    localparam int SUM_W     = 2 * COORD_BITS + 1;
    localparam int SQN_W     = SUM_W + 16;
    localparam int SQN_WE    = SQN_W + (SQN_W % 2);
    localparam int ROOT_W    = SQN_WE / 2;
    localparam int REM_W     = ROOT_W + 3;

    // coordinate angles: v * RAD + D * 2^15, divided by D * 2^16
    localparam int PROD_W = COORD_BITS + 1 + RAD_W;
    localparam int QUO_W  = PROD_W - 16;
    localparam int REC_K  = QUO_W + 3;
    localparam int RECP_W = QUO_W + REC_K;
    localparam logic [REC_K-1:0] REC7 = REC_K'(((64'd1 << REC_K) + 64'd6) / 64'd7);
    localparam logic [REC_K-1:0] REC5 = REC_K'(((64'd1 << REC_K) + 64'd4) / 64'd5);
    localparam logic [REC_K-1:0] REC6 = REC_K'(((64'd1 << REC_K) + 64'd5) / 64'd6);
    localparam logic [PROD_W-1:0] RAD_P = PROD_W'(RAD_Q16);
    localparam logic [PROD_W-1:0] OFF7  = PROD_W'(7 * 32768);
    localparam logic [PROD_W-1:0] OFF5  = PROD_W'(5 * 32768);
    localparam logic [PROD_W-1:0] OFF6  = PROD_W'(6 * 32768);

    // radius angle: r * RAD + 2^25, divided by 4 * 2^8 * 2^16
    localparam int ROOT_PROD_W = ROOT_W + RAD_W;
    localparam int ROOT_SHIFT  = 26;
    localparam logic [ROOT_PROD_W-1:0] RAD_R    = ROOT_PROD_W'(RAD_Q16);
    localparam logic [ROOT_PROD_W-1:0] ROOT_OFF = ROOT_PROD_W'(64'd1 << 25);

    localparam int QTR_BITS = SINE_TABLE_BITS - 2;
    localparam int QTR_N    = 1 << QTR_BITS;

    typedef logic [MAG_W-1:0] t_qtab [0:QTR_N];

    typedef struct packed {
        logic                 valid;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
        logic [SQN_WE-1:0]    bits;
        logic [ANGLE_W-1:0]   ang_a;
        logic [ANGLE_W-1:0]   ang_b;
        logic [ANGLE_W-1:0]   ang_c;
    } t_sq_lane;

    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] xr;
        logic [63:0] x2;
        logic [63:0] a;
        xr = (u * PI_Q30) / 64'd32768;
        x2 = (xr * xr) >> 30;
        a  = ONE_Q30 - x2 / 64'd72;
        a  = ONE_Q30 - ((x2 * a) >> 30) / 64'd42;
        a  = ONE_Q30 - ((x2 * a) >> 30) / 64'd20;
        a  = ONE_Q30 - ((x2 * a) >> 30) / 64'd6;
        return (xr * a) >> 30;
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab       t;
        logic [63:0] s;
        logic [63:0] m;
        for (int k = 0; k <= QTR_N; k++) begin
            s = quarter_sine(64'(k * (65536 >> SINE_TABLE_BITS)));
            m = (s * 64'(AMP_Q8) + (64'd1 << 29)) >> 30;
            if (m > 64'(AMP_Q8)) begin
                m = 64'(AMP_Q8);
            end
            t[k] = MAG_W'(m);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

endpackage

>>> rtl/core/sppg_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppg_sqrt_stage
// One registered digit step of the radius square root; carries the
// coordinate angles alongside.
// ----------------------------------------------------------------------------
module sppg_sqrt_stage
    import sppg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sq_lane i_lane,
    output t_sq_lane o_lane
);

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
        rem2  = {i_lane.rem[REM_W-3:0], i_lane.bits[SQN_WE-1 -: 2]};
        trial = REM_W'({i_lane.root, 2'b01});
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_lane.valid <= 1'b0;
        end else begin
            o_lane.valid <= i_lane.valid;
        end
        o_lane.rem   <= ge ? (rem2 - trial) : rem2;
        o_lane.root  <= {i_lane.root[ROOT_W-2:0], ge};
        o_lane.bits  <= {i_lane.bits[SQN_WE-3:0], 2'b00};
        o_lane.ang_a <= i_lane.ang_a;
        o_lane.ang_b <= i_lane.ang_b;
        o_lane.ang_c <= i_lane.ang_c;
    end

endmodule

>>> rtl/core/sppg_sine_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppg_sine_term
// Angle to plasma term 127 + 127*sin in Q8, by quarter-wave fold of the
// sine table; registered output.
// ----------------------------------------------------------------------------
module sppg_sine_term
    import sppg_pkg::*;
(
    input  logic               i_clk,
    input  logic [ANGLE_W-1:0] i_angle,
    output logic [TERM_W-1:0]  o_term
);

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [QTR_BITS:0]          k;
    logic [MAG_W-1:0]           mag;

    always_comb begin
        idx = i_angle[ANGLE_W-1 -: SINE_TABLE_BITS];
        if (idx[QTR_BITS]) begin
            k = (QTR_BITS+1)'(QTR_N) - {1'b0, idx[QTR_BITS-1:0]};
        end else begin
            k = {1'b0, idx[QTR_BITS-1:0]};
        end
        mag = QTAB[k];
    end

    always_ff @(posedge i_clk) begin
        if (idx[SINE_TABLE_BITS-1]) begin
            o_term <= TERM_W'(AMP_Q8) - TERM_W'(mag);
        end else begin
            o_term <= TERM_W'(AMP_Q8) + TERM_W'(mag);
        end
    end

endmodule

>>> rtl/core/sine_plasma_pixel_generator.sv
`timescale 1ns / 1ps
// Pipeline: accepted pixels pass the input stages, the radius square root digit
// steps (one per stage) and the arithmetic stages to the result strobe.
// Throughput: one pixel per cycle; busy stays low, the pipeline never stalls.
// Reset: synchronous, active low; clears all valid bits and the phase to 0.
// ----------------------------------------------------------------------------
// sine_plasma_pixel_generator
// Pipelined sine plasma: four sine terms of pixel coordinates and phase,
// averaged to a grey level.
// ----------------------------------------------------------------------------
module sine_plasma_pixel_generator
    import sppg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [9:0]        i_pixel_x,
    input  logic [9:0]        i_pixel_y,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    output logic              o_valid,
    output logic [GREY_W-1:0] o_grey_level
);

    logic [ANGLE_W-1:0] r_time;

    logic                  r1_v;
    logic [COORD_BITS-1:0] r1_x, r1_y;

    logic              r2_v;
    logic [SUM_W-1:0]  r2_sq;
    logic [PROD_W-1:0] r2_pa, r2_pb, r2_pc;

    logic              r3_v;
    logic [SUM_W-1:0]  r3_sq;
    logic [RECP_W-1:0] r3_ma, r3_mb, r3_mc;

    t_sq_lane lane [0:ROOT_W];

    logic                   r24_v;
    logic [ROOT_PROD_W-1:0] r24_pr;
    logic [ANGLE_W-1:0]     r24_a, r24_b, r24_c;
    logic [ANGLE_W-1:0]     ang_r;

    logic              r25_v;
    logic [TERM_W-1:0] term_a, term_b, term_c, term_r;
    logic [SUM4_W-1:0] sum4;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cfg_we) begin
            r_time <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        r1_x  <= i_pixel_x[COORD_BITS-1:0];
        r1_y  <= i_pixel_y[COORD_BITS-1:0];
        r2_sq <= SUM_W'(r1_x) * SUM_W'(r1_x) + SUM_W'(r1_y) * SUM_W'(r1_y);
        r2_pa <= PROD_W'(r1_x) * RAD_P + OFF7;
        r2_pb <= PROD_W'(r1_y) * RAD_P + OFF5;
        r2_pc <= (PROD_W'(r1_x) + PROD_W'(r1_y)) * RAD_P + OFF6;
        r3_sq <= r2_sq;
        r3_ma <= RECP_W'(r2_pa[PROD_W-1:16]) * RECP_W'(REC7);
        r3_mb <= RECP_W'(r2_pb[PROD_W-1:16]) * RECP_W'(REC5);
        r3_mc <= RECP_W'(r2_pc[PROD_W-1:16]) * RECP_W'(REC6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            lane[0].valid <= 1'b0;
        end else begin
            lane[0].valid <= r3_v;
        end
        lane[0].rem   <= '0;
        lane[0].root  <= '0;
        lane[0].bits  <= SQN_WE'({r3_sq, 16'h0000});
        lane[0].ang_a <= r3_ma[REC_K +: ANGLE_W] + r_time;
        lane[0].ang_b <= r3_mb[REC_K +: ANGLE_W] - r_time;
        lane[0].ang_c <= r3_mc[REC_K +: ANGLE_W] - r_time;
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        sppg_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (lane[g]),
            .o_lane  (lane[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r24_v <= 1'b0;
            r25_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r24_v <= lane[ROOT_W].valid;
            r25_v <= r24_v;
            o_valid <= r25_v;
        end
        r24_pr <= ROOT_PROD_W'(lane[ROOT_W].root) * RAD_R + ROOT_OFF;
        r24_a  <= lane[ROOT_W].ang_a;
        r24_b  <= lane[ROOT_W].ang_b;
        r24_c  <= lane[ROOT_W].ang_c;
        o_grey_level <= sum4[SUM4_W-1 -: GREY_W];
    end

    assign ang_r = r24_pr[ROOT_SHIFT +: ANGLE_W] - r_time;

    sppg_sine_term u_term_a (.i_clk(i_clk), .i_angle(r24_a), .o_term(term_a));
    sppg_sine_term u_term_b (.i_clk(i_clk), .i_angle(r24_b), .o_term(term_b));
    sppg_sine_term u_term_c (.i_clk(i_clk), .i_angle(r24_c), .o_term(term_c));
    sppg_sine_term u_term_r (.i_clk(i_clk), .i_angle(ang_r), .o_term(term_r));

    assign sum4 = SUM4_W'(term_a) + SUM4_W'(term_b) + SUM4_W'(term_c) + SUM4_W'(term_r);

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r1_v)
        else $error("accepted transaction did not enter the pipeline");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r25_v))
        else $error("result strobe without a transaction in the last stage");

    a_sqrt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r24_v |-> $past(lane[ROOT_W].valid))
        else $error("radius lane valid lost");

    a_grey_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_grey_level <= 8'd254))
        else $error("grey level out of range");

endmodule
